/* rtl/core/ltb_pkg.sv */
// Shared types and constants for the leader trail buffer.
// Used by the channel interfaces, the control path, the divider, the trail memory and the top.
package ltb_pkg;

  localparam int unsigned TRAIL_DEPTH_DEF = 256;
  localparam int unsigned COORD_W         = 32;
  localparam int unsigned DELTA_W         = COORD_W + 1;
  localparam int unsigned QUOT_W          = COORD_W + 2;
  localparam int unsigned AXES            = 3;
  localparam int unsigned IDX_W           = 8;
  localparam int unsigned IDX_N           = 1 << IDX_W;
  localparam int unsigned SPACING_W       = 31;
  localparam int unsigned LIM_W           = 2 * SPACING_W;
  localparam int unsigned SQ_W            = 2 * COORD_W;
  localparam int unsigned STATUS_W        = 3;
  localparam int unsigned APB_DATA_W      = 32;
  localparam int unsigned APB_ADDR_W      = 3;

  localparam logic [SPACING_W-1:0] MIN_SPACING_RST = 31'd13107;

  localparam logic CMD_UPDATE = 1'b0;
  localparam logic CMD_READ   = 1'b1;

  // register index as decoded from paddr[2]
  localparam logic REG_MIN_SPACING = 1'b0;

  typedef enum logic [STATUS_W-1:0] {
    ST_FILLED,
    ST_APPENDED,
    ST_TOO_CLOSE,
    ST_READ_DONE,
    ST_READ_EARLY
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RD_ADDR,
    S_RD_DATA,
    S_FILL_START,
    S_FILL_DIV,
    S_FILL_RUN,
    S_UPD_ABS,
    S_UPD_SQX,
    S_UPD_SQY,
    S_UPD_LIM,
    S_UPD_CMP,
    S_DONE
  } ctrl_state_e;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
  } point_t;

  typedef struct packed {
    logic                      command;
    logic signed [COORD_W-1:0] follower_x;
    logic signed [COORD_W-1:0] follower_y;
    logic signed [COORD_W-1:0] follower_z;
    logic signed [COORD_W-1:0] leader_x;
    logic signed [COORD_W-1:0] leader_y;
    logic signed [COORD_W-1:0] leader_z;
    logic [IDX_W-1:0]          entry_index;
  } item_t;

endpackage

/* rtl/core/ltb_in_if.sv */
// Input channel of the leader trail buffer: valid/ready plus command payload.
// Depends on ltb_pkg.
interface ltb_in_if;
  import ltb_pkg::*;

  logic                      valid;
  logic                      ready;
  logic                      command;
  logic signed [COORD_W-1:0] follower_x;
  logic signed [COORD_W-1:0] follower_y;
  logic signed [COORD_W-1:0] follower_z;
  logic signed [COORD_W-1:0] leader_x;
  logic signed [COORD_W-1:0] leader_y;
  logic signed [COORD_W-1:0] leader_z;
  logic [IDX_W-1:0]          entry_index;

  modport source (
    output valid, command, follower_x, follower_y, follower_z,
    output leader_x, leader_y, leader_z, entry_index,
    input  ready
  );

  modport sink (
    input  valid, command, follower_x, follower_y, follower_z,
    input  leader_x, leader_y, leader_z, entry_index,
    output ready
  );

endinterface

/* rtl/core/ltb_out_if.sv */
// Result channel of the leader trail buffer: valid/ready plus status and point.
// Depends on ltb_pkg.
interface ltb_out_if;
  import ltb_pkg::*;

  logic                      valid;
  logic                      ready;
  logic [STATUS_W-1:0]       status;
  logic signed [COORD_W-1:0] point_x;
  logic signed [COORD_W-1:0] point_y;
  logic signed [COORD_W-1:0] point_z;

  modport source (
    output valid, status, point_x, point_y, point_z,
    input  ready
  );

  modport sink (
    input  valid, status, point_x, point_y, point_z,
    output ready
  );

endinterface

/* rtl/core/leader_trail_buffer.sv */
// Channel  Dir  Handshake                 Payload
// in_if    in   valid/ready               command, follower_x/y/z, leader_x/y/z, entry_index
// out_if   out  valid/ready               status, point_x/y/z
// apb      in   psel/penable/pwrite/pready min_spacing at byte address 0
//
// One item at a time. The distance check of an update runs two squares and the spacing limit
// through one shared 32x32 multiplier. The first update fills the trail: a shift and mask of
// the span by TRAIL_DEPTH, then one memory write per entry through the single write port.
// Reset clears control state only; the trail memory needs no clearing pass.
// The result register lets a new item transfer in while the last result waits; an item
// holds in its final cycle until the result register is free.
module leader_trail_buffer #(
  parameter int unsigned TRAIL_DEPTH = ltb_pkg::TRAIL_DEPTH_DEF,
  localparam int unsigned AW = $clog2(TRAIL_DEPTH)
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  ltb_in_if.sink                             in_if,
  ltb_out_if.source                          out_if,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [ltb_pkg::APB_ADDR_W-1:0]     paddr,
  input  logic [ltb_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [ltb_pkg::APB_DATA_W-1:0]     prdata,
  output logic                               pready
);
  import ltb_pkg::*;

  logic [SPACING_W-1:0]     min_spacing_q;
  logic                     cfg_wr;
  logic                     reg_sel;

  logic                     mem_we;
  logic [AW-1:0]            mem_waddr;
  point_t                   mem_wdata;
  logic                     mem_re;
  logic [AW-1:0]            mem_raddr;
  point_t                   mem_rdata;

  logic                     div_start;
  logic signed [DELTA_W-1:0] div_delta [AXES];
  logic                     div_done;
  logic signed [QUOT_W-1:0] div_quot [AXES];
  logic [AW-1:0]            div_rem [AXES];

  assign pready  = 1'b1;
  assign reg_sel = paddr[APB_ADDR_W-1] == REG_MIN_SPACING;
  assign cfg_wr  = psel && penable && pwrite && pready && reg_sel;
  assign prdata  = reg_sel ? {1'b0, min_spacing_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_spacing_q <= MIN_SPACING_RST;
    end else if (cfg_wr) begin
      min_spacing_q <= pwdata[SPACING_W-1:0];
    end
  end

  ltb_ctrl #(
    .TRAIL_DEPTH (TRAIL_DEPTH)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .min_spacing_i (min_spacing_q),
    .in_if         (in_if),
    .out_if        (out_if),
    .mem_we_o      (mem_we),
    .mem_waddr_o   (mem_waddr),
    .mem_wdata_o   (mem_wdata),
    .mem_re_o      (mem_re),
    .mem_raddr_o   (mem_raddr),
    .mem_rdata_i   (mem_rdata),
    .div_start_o   (div_start),
    .div_delta_o   (div_delta),
    .div_done_i    (div_done),
    .div_quot_i    (div_quot),
    .div_rem_i     (div_rem)
  );

  ltb_trail_mem #(
    .TRAIL_DEPTH (TRAIL_DEPTH)
  ) u_trail_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  ltb_div #(
    .TRAIL_DEPTH (TRAIL_DEPTH)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .delta_i (div_delta),
    .done_o  (div_done),
    .quot_o  (div_quot),
    .rem_o   (div_rem)
  );

  // only a read result carries a point
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid && (out_if.status != ST_READ_DONE) |->
      (out_if.point_x == '0) && (out_if.point_y == '0) && (out_if.point_z == '0))
    else $error("nonzero point on a result that is not a read");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_if.valid && in_if.ready |=> !in_if.ready)
    else $error("second transfer taken while an item is in flight");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_wr |=> (min_spacing_q == $past(pwdata[SPACING_W-1:0])))
    else $error("min_spacing write lost");

endmodule

/* rtl/core/ltb_div.sv */
// Three-lane span scaler for the fill: floor division of signed spans by a power-of-two
// TRAIL_DEPTH as an arithmetic shift and a mask, result in the cycle after start. Depends on ltb_pkg.
module ltb_div #(
  parameter int unsigned TRAIL_DEPTH = ltb_pkg::TRAIL_DEPTH_DEF,
  localparam int unsigned AW = $clog2(TRAIL_DEPTH)
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic signed [ltb_pkg::DELTA_W-1:0] delta_i [ltb_pkg::AXES],
  output logic                              done_o,
  output logic signed [ltb_pkg::QUOT_W-1:0]  quot_o [ltb_pkg::AXES],
  output logic [AW-1:0]                     rem_o [ltb_pkg::AXES]
);
  import ltb_pkg::*;

  logic                     done_q;
  logic signed [QUOT_W-1:0] quot_q [AXES];
  logic [AW-1:0]            rem_q  [AXES];

  assign done_o = done_q;
  assign quot_o = quot_q;
  assign rem_o  = rem_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= start_i;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int a = 0; a < AXES; a++) begin
      if (start_i) begin
        quot_q[a] <= $signed({{(QUOT_W - DELTA_W){delta_i[a][DELTA_W-1]}}, delta_i[a]}) >>> AW;
        rem_q[a]  <= delta_i[a][AW-1:0];
      end
    end
  end

endmodule

/* rtl/core/ltb_trail_mem.sv */
// Trail point memory: one write port, one read port, registered read data.
// Depends on ltb_pkg for the point type.
module ltb_trail_mem #(
  parameter int unsigned TRAIL_DEPTH = ltb_pkg::TRAIL_DEPTH_DEF,
  localparam int unsigned AW = $clog2(TRAIL_DEPTH)
) (
  input  logic            clk_i,
  input  logic            we_i,
  input  logic [AW-1:0]   waddr_i,
  input  ltb_pkg::point_t wdata_i,
  input  logic            re_i,
  input  logic [AW-1:0]   raddr_i,
  output ltb_pkg::point_t rdata_o
);
  import ltb_pkg::*;

  point_t mem_q [TRAIL_DEPTH];
  point_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/core/ltb_ctrl.sv */
// Control and datapath of the leader trail buffer: fill sweep, spacing check, ring reads,
// result register. Depends on ltb_pkg, ltb_in_if, ltb_out_if; drives ltb_trail_mem and ltb_div.
module ltb_ctrl #(
  parameter int unsigned TRAIL_DEPTH = ltb_pkg::TRAIL_DEPTH_DEF,
  localparam int unsigned AW = $clog2(TRAIL_DEPTH)
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic [ltb_pkg::SPACING_W-1:0]       min_spacing_i,
  ltb_in_if.sink                              in_if,
  ltb_out_if.source                           out_if,
  output logic                                mem_we_o,
  output logic [AW-1:0]                       mem_waddr_o,
  output ltb_pkg::point_t                     mem_wdata_o,
  output logic                                mem_re_o,
  output logic [AW-1:0]                       mem_raddr_o,
  input  ltb_pkg::point_t                     mem_rdata_i,
  output logic                                div_start_o,
  output logic signed [ltb_pkg::DELTA_W-1:0]  div_delta_o [ltb_pkg::AXES],
  input  logic                                div_done_i,
  input  logic signed [ltb_pkg::QUOT_W-1:0]   div_quot_i [ltb_pkg::AXES],
  input  logic [AW-1:0]                       div_rem_i [ltb_pkg::AXES]
);
  import ltb_pkg::*;

  localparam logic [AW-1:0] LastSlot = AW'(TRAIL_DEPTH - 1);
  localparam logic [AW:0]   DepthW   = (AW + 1)'(TRAIL_DEPTH);

  ctrl_state_e state_q, state_d;

  logic                 filled_q;
  logic [AW-1:0]        oldest_q;
  logic [COORD_W-1:0]   newest_x_q;
  logic [COORD_W-1:0]   newest_y_q;
  logic                 out_valid_q;
  status_e              out_status_q;
  point_t               out_pt_q;

  item_t                item_q;
  status_e              res_status_q;
  point_t               res_pt_q;

  logic signed [QUOT_W-1:0] dq_q [AXES];
  logic [AW-1:0]            dr_q [AXES];
  logic signed [QUOT_W-1:0] q_q  [AXES];
  logic [AW-1:0]            r_q  [AXES];
  logic [AW-1:0]            slot_q;

  logic [DELTA_W-1:0]   mag_x_q;
  logic [DELTA_W-1:0]   mag_y_q;
  logic [SQ_W-1:0]      sq_x_q;
  logic [SQ_W-1:0]      sq_y_q;
  logic [LIM_W-1:0]     lim_q;

  logic signed [COORD_W-1:0] fol  [AXES];
  logic signed [COORD_W-1:0] lead [AXES];
  logic [AW:0]               r_sum [AXES];
  logic [AW:0]               r_sub [AXES];
  logic [AXES-1:0]           wrap;
  logic [AW-1:0]             r_n  [AXES];
  logic signed [QUOT_W-1:0]  q_n  [AXES];
  logic [COORD_W-1:0]        fill_val [AXES];
  point_t                    fill_pt;
  point_t                    lead_pt;

  logic [AW-1:0]        idx_mod [IDX_N];
  logic [AW:0]          rd_sum;
  logic [AW:0]          rd_sub;
  logic [AW-1:0]        rd_slot;
  logic [AW-1:0]        oldest_next;

  logic [DELTA_W-1:0]   dx;
  logic [DELTA_W-1:0]   dy;
  logic [COORD_W-1:0]   mul_a;
  logic [COORD_W-1:0]   mul_b;
  logic [SQ_W-1:0]      prod;
  logic [SQ_W:0]        sum_raw;
  logic [SQ_W-1:0]      sum_sat;
  logic                 far;

  logic                 accept;
  logic                 out_load;
  logic                 fill_last;
  logic                 append;

  for (genvar g = 0; g < IDX_N; g++) begin : g_idx_mod
    assign idx_mod[g] = AW'(g % TRAIL_DEPTH);
  end

  assign fol[0]  = item_q.follower_x;
  assign fol[1]  = item_q.follower_y;
  assign fol[2]  = item_q.follower_z;
  assign lead[0] = item_q.leader_x;
  assign lead[1] = item_q.leader_y;
  assign lead[2] = item_q.leader_z;

  always_comb begin
    for (int a = 0; a < AXES; a++) begin
      div_delta_o[a] = {lead[a][COORD_W-1], lead[a]} - {fol[a][COORD_W-1], fol[a]};
      r_sum[a]       = {1'b0, r_q[a]} + {1'b0, dr_q[a]};
      wrap[a]        = r_sum[a] >= DepthW;
      r_sub[a]       = r_sum[a] - DepthW;
      r_n[a]         = wrap[a] ? r_sub[a][AW-1:0] : r_sum[a][AW-1:0];
      q_n[a]         = q_q[a] + dq_q[a] + {{(QUOT_W-1){1'b0}}, wrap[a]};
      fill_val[a]    = fol[a] + q_n[a][COORD_W-1:0];
    end
  end

  assign fill_pt = {fill_val[0], fill_val[1], fill_val[2]};
  assign lead_pt = {item_q.leader_x, item_q.leader_y, item_q.leader_z};

  // ring slot of a read, counted from the oldest entry
  assign rd_sum      = {1'b0, oldest_q} + {1'b0, idx_mod[item_q.entry_index]};
  assign rd_sub      = rd_sum - DepthW;
  assign rd_slot     = (rd_sum >= DepthW) ? rd_sub[AW-1:0] : rd_sum[AW-1:0];
  assign oldest_next = (oldest_q == LastSlot) ? '0 : oldest_q + 1'b1;

  assign dx = {item_q.leader_x[COORD_W-1], item_q.leader_x} - {newest_x_q[COORD_W-1], newest_x_q};
  assign dy = {item_q.leader_y[COORD_W-1], item_q.leader_y} - {newest_y_q[COORD_W-1], newest_y_q};

  // one shared multiplier for both squares and the spacing limit
  always_comb begin
    case (state_q)
      S_UPD_SQX: begin
        mul_a = mag_x_q[COORD_W-1:0];
        mul_b = mag_x_q[COORD_W-1:0];
      end
      S_UPD_SQY: begin
        mul_a = mag_y_q[COORD_W-1:0];
        mul_b = mag_y_q[COORD_W-1:0];
      end
      default: begin
        mul_a = {1'b0, min_spacing_i};
        mul_b = {1'b0, min_spacing_i};
      end
    endcase
  end

  assign prod    = mul_a * mul_b;
  assign sum_raw = {1'b0, sq_x_q} + {1'b0, sq_y_q};
  assign sum_sat = sum_raw[SQ_W] ? '1 : sum_raw[SQ_W-1:0];
  assign far     = sum_sat > {{(SQ_W - LIM_W){1'b0}}, lim_q};

  assign accept    = in_if.valid && in_if.ready;
  assign fill_last = (state_q == S_FILL_RUN) && (slot_q == LastSlot);
  assign append    = (state_q == S_UPD_CMP) && far;

  always_comb begin
    state_d     = state_q;
    in_if.ready = 1'b0;
    div_start_o = 1'b0;
    mem_we_o    = 1'b0;
    mem_waddr_o = oldest_q;
    mem_wdata_o = lead_pt;
    mem_re_o    = 1'b0;
    mem_raddr_o = rd_slot;
    out_load    = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_if.ready = 1'b1;
        if (in_if.valid) begin
          if (in_if.command == CMD_READ) begin
            state_d = filled_q ? S_RD_ADDR : S_DONE;
          end else begin
            state_d = filled_q ? S_UPD_ABS : S_FILL_START;
          end
        end
      end
      S_RD_ADDR: begin
        mem_re_o = 1'b1;
        state_d  = S_RD_DATA;
      end
      S_RD_DATA: state_d = S_DONE;
      S_FILL_START: begin
        div_start_o = 1'b1;
        state_d     = S_FILL_DIV;
      end
      S_FILL_DIV: begin
        if (div_done_i) begin
          state_d = S_FILL_RUN;
        end
      end
      S_FILL_RUN: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = slot_q;
        mem_wdata_o = fill_pt;
        if (slot_q == LastSlot) begin
          state_d = S_DONE;
        end
      end
      S_UPD_ABS: state_d = S_UPD_SQX;
      S_UPD_SQX: state_d = S_UPD_SQY;
      S_UPD_SQY: state_d = S_UPD_LIM;
      S_UPD_LIM: state_d = S_UPD_CMP;
      S_UPD_CMP: begin
        mem_we_o = far;
        state_d  = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_q || out_if.ready) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      filled_q    <= 1'b0;
      oldest_q    <= '0;
      newest_x_q  <= '0;
      newest_y_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_q <= 1'b0;
      end
      if (fill_last) begin
        filled_q   <= 1'b1;
        oldest_q   <= '0;
        newest_x_q <= item_q.leader_x;
        newest_y_q <= item_q.leader_y;
      end
      if (append) begin
        oldest_q   <= oldest_next;
        newest_x_q <= item_q.leader_x;
        newest_y_q <= item_q.leader_y;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q       <= {in_if.command, in_if.follower_x, in_if.follower_y, in_if.follower_z,
                       in_if.leader_x, in_if.leader_y, in_if.leader_z, in_if.entry_index};
      res_status_q <= ST_READ_EARLY;
      res_pt_q     <= '0;
    end
    case (state_q)
      S_RD_DATA: begin
        res_status_q <= ST_READ_DONE;
        res_pt_q     <= mem_rdata_i;
      end
      S_FILL_DIV: begin
        if (div_done_i) begin
          for (int a = 0; a < AXES; a++) begin
            dq_q[a] <= div_quot_i[a];
            dr_q[a] <= div_rem_i[a];
            q_q[a]  <= '0;
            r_q[a]  <= '0;
          end
          slot_q <= '0;
        end
      end
      S_FILL_RUN: begin
        for (int a = 0; a < AXES; a++) begin
          q_q[a] <= q_n[a];
          r_q[a] <= r_n[a];
        end
        slot_q       <= slot_q + 1'b1;
        res_status_q <= ST_FILLED;
        res_pt_q     <= '0;
      end
      S_UPD_ABS: begin
        mag_x_q <= dx[DELTA_W-1] ? (~dx + 1'b1) : dx;
        mag_y_q <= dy[DELTA_W-1] ? (~dy + 1'b1) : dy;
      end
      S_UPD_SQX: sq_x_q <= mag_x_q[DELTA_W-1] ? '1 : prod;
      S_UPD_SQY: sq_y_q <= mag_y_q[DELTA_W-1] ? '1 : prod;
      S_UPD_LIM: lim_q  <= prod[LIM_W-1:0];
      S_UPD_CMP: begin
        res_status_q <= far ? ST_APPENDED : ST_TOO_CLOSE;
        res_pt_q     <= '0;
      end
      S_DONE: begin
        if (out_load) begin
          out_status_q <= res_status_q;
          out_pt_q     <= res_pt_q;
        end
      end
      default: ;
    endcase
  end

  assign out_if.valid   = out_valid_q;
  assign out_if.status  = out_status_q;
  assign out_if.point_x = out_pt_q.x;
  assign out_if.point_y = out_pt_q.y;
  assign out_if.point_z = out_pt_q.z;

endmodule

/* bench/tb_leader_trail_buffer.sv */
// Testbench for leader_trail_buffer: a table of directed commands, then random phases with
// different spacing settings and handshake pressure, checked by table or local predictor.
// Depends on ltb_pkg, ltb_in_if, ltb_out_if and the leader_trail_buffer RTL.
module tb_leader_trail_buffer;
  import ltb_pkg::*;

  localparam logic [COORD_W-1:0]    COORD_MAX        = 32'h7FFF_FFFF;
  localparam logic [COORD_W-1:0]    COORD_MIN        = 32'h8000_0000;
  localparam logic [COORD_W-1:0]    RST_SPACING      = COORD_W'(MIN_SPACING_RST);
  localparam logic [APB_ADDR_W-1:0] MIN_SPACING_ADDR = {REG_MIN_SPACING, 2'b00};
  localparam int                    PHASES           = 6;
  localparam int                    ITEMS_PER_PHASE  = 320;
  localparam int                    SETTLE_CYCLES    = 8;
  localparam int                    DRAIN_LIMIT      = 20000;

  typedef struct packed {
    status_e status;
    point_t  point;
  } trail_result_t;

  typedef struct {
    item_t         stim;
    bit            typed;
    trail_result_t want;
  } directed_row_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  ltb_in_if  in_if ();
  ltb_out_if out_if ();

  leader_trail_buffer i_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_if   (in_if),
    .out_if  (out_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // predicted trail state
  logic signed [COORD_W-1:0] ring_x [TRAIL_DEPTH_DEF];
  logic signed [COORD_W-1:0] ring_y [TRAIL_DEPTH_DEF];
  logic signed [COORD_W-1:0] ring_z [TRAIL_DEPTH_DEF];
  logic [IDX_W-1:0]          ring_head = '0;
  logic                      ring_full = 1'b0;
  logic signed [COORD_W-1:0] last_x    = '0;
  logic signed [COORD_W-1:0] last_y    = '0;
  logic [SPACING_W-1:0]      spacing_reg = MIN_SPACING_RST;

  trail_result_t pending_trail_results[$];
  int            mismatch_count     = 0;
  int            sender_idle_pct    = 0;
  int            receiver_stall_pct = 0;

  function automatic logic signed [COORD_W-1:0] fill_coord(
    input logic signed [COORD_W-1:0] from_c,
    input logic signed [COORD_W-1:0] to_c,
    input int                        step
  );
    longint prod;
    prod = (longint'(to_c) - longint'(from_c)) * longint'(step);
    return COORD_W'(longint'(from_c) + (prod >>> $clog2(TRAIL_DEPTH_DEF)));
  endfunction

  function automatic trail_result_t predict_trail_result(input item_t it);
    trail_result_t    res;
    logic [IDX_W-1:0] slot;
    longint           dx;
    longint           dy;
    logic [SQ_W-1:0]  sq_x;
    logic [SQ_W-1:0]  sq_y;
    logic [SQ_W-1:0]  limit_sq;
    logic [SQ_W:0]    dist_sq;
    res = '{status: ST_READ_EARLY, point: '0};
    if (it.command == CMD_UPDATE && !ring_full) begin
      for (int i = 1; i <= TRAIL_DEPTH_DEF; i++) begin
        ring_x[i-1] = fill_coord(it.follower_x, it.leader_x, i);
        ring_y[i-1] = fill_coord(it.follower_y, it.leader_y, i);
        ring_z[i-1] = fill_coord(it.follower_z, it.leader_z, i);
      end
      ring_head  = '0;
      last_x     = it.leader_x;
      last_y     = it.leader_y;
      ring_full  = 1'b1;
      res.status = ST_FILLED;
    end else if (it.command == CMD_UPDATE) begin
      dx       = longint'(it.leader_x) - longint'(last_x);
      dy       = longint'(it.leader_y) - longint'(last_y);
      sq_x     = SQ_W'(dx < 0 ? -dx : dx);
      sq_y     = SQ_W'(dy < 0 ? -dy : dy);
      sq_x     = sq_x * sq_x;
      sq_y     = sq_y * sq_y;
      dist_sq  = {1'b0, sq_x} + {1'b0, sq_y};
      if (dist_sq[SQ_W]) begin
        dist_sq = {1'b0, {SQ_W{1'b1}}};
      end
      limit_sq = SQ_W'(spacing_reg) * SQ_W'(spacing_reg);
      if (dist_sq[SQ_W-1:0] > limit_sq) begin
        ring_x[ring_head] = it.leader_x;
        ring_y[ring_head] = it.leader_y;
        ring_z[ring_head] = it.leader_z;
        last_x            = it.leader_x;
        last_y            = it.leader_y;
        ring_head         = ring_head + 1'b1;
        res.status        = ST_APPENDED;
      end else begin
        res.status = ST_TOO_CLOSE;
      end
    end else if (ring_full) begin
      slot       = ring_head + it.entry_index;
      res.status = ST_READ_DONE;
      res.point  = '{ring_x[slot], ring_y[slot], ring_z[slot]};
    end
    return res;
  endfunction

  function automatic directed_row_t mk_row(
    input logic               cmd,
    input logic [COORD_W-1:0] fx, fy, fz, lx, ly, lz,
    input logic [IDX_W-1:0]   idx,
    input bit                 typed = 1'b0,
    input status_e            st = ST_FILLED,
    input logic [COORD_W-1:0] px = '0, py = '0, pz = '0
  );
    directed_row_t r;
    r.stim  = '{cmd, fx, fy, fz, lx, ly, lz, idx};
    r.typed = typed;
    r.want  = '{status: st, point: '{px, py, pz}};
    return r;
  endfunction

  task automatic send_item(input item_t it, input bit typed, input trail_result_t want);
    trail_result_t predicted;
    while ($urandom_range(99) < sender_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid       <= 1'b1;
    in_if.command     <= it.command;
    in_if.follower_x  <= it.follower_x;
    in_if.follower_y  <= it.follower_y;
    in_if.follower_z  <= it.follower_z;
    in_if.leader_x    <= it.leader_x;
    in_if.leader_y    <= it.leader_y;
    in_if.leader_z    <= it.leader_z;
    in_if.entry_index <= it.entry_index;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    predicted = predict_trail_result(it);
    if (typed) begin
      predicted = want;
    end
    pending_trail_results.insert(pending_trail_results.size(), predicted);
  endtask

  task automatic drain_results();
    int waited;
    waited = 0;
    in_if.valid <= 1'b0;
    while (pending_trail_results.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk_i);
      waited++;
    end
    if (pending_trail_results.size() != 0) begin
      $error("%0d result transfers never arrived", pending_trail_results.size());
      mismatch_count++;
      pending_trail_results.delete();
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic apb_transfer(input logic wr, input logic [APB_DATA_W-1:0] wdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= MIN_SPACING_ADDR;
    pwdata  <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if (!wr && prdata !== APB_DATA_W'(spacing_reg)) begin
      $error("min_spacing readback mismatch: expected %0d, got %0d", spacing_reg, prdata);
      mismatch_count++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  // result side: random stalls, compare against oldest expectation
  initial begin
    trail_result_t exp_res;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_if.valid && out_if.ready) begin
        if (pending_trail_results.size() == 0) begin
          $error("result transfer with nothing expected: status %0d", out_if.status);
          mismatch_count++;
        end else begin
          exp_res = pending_trail_results[0];
          pending_trail_results.delete(0);
          if (out_if.status !== exp_res.status) begin
            $error("status mismatch: expected %0d, got %0d", exp_res.status, out_if.status);
            mismatch_count++;
          end
          if (out_if.point_x !== exp_res.point.x) begin
            $error("point_x mismatch: expected %0h, got %0h", exp_res.point.x,
                   out_if.point_x);
            mismatch_count++;
          end
          if (out_if.point_y !== exp_res.point.y) begin
            $error("point_y mismatch: expected %0h, got %0h", exp_res.point.y,
                   out_if.point_y);
            mismatch_count++;
          end
          if (out_if.point_z !== exp_res.point.z) begin
            $error("point_z mismatch: expected %0h, got %0h", exp_res.point.z,
                   out_if.point_z);
            mismatch_count++;
          end
        end
      end
      out_if.ready <= ($urandom_range(99) >= receiver_stall_pct);
    end
  end

  initial begin
    #5_000_000;
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    directed_row_t directed_rows[$];
    item_t         it;
    longint        dx;
    longint        dy;
    longint        swap;
    int            mode;
    int unsigned   phase_spacing [PHASES];
    int            phase_idle    [PHASES];
    int            phase_stall   [PHASES];

    rst_ni            <= 1'b0;
    in_if.valid       <= 1'b0;
    in_if.command     <= CMD_UPDATE;
    in_if.follower_x  <= '0;
    in_if.follower_y  <= '0;
    in_if.follower_z  <= '0;
    in_if.leader_x    <= '0;
    in_if.leader_y    <= '0;
    in_if.leader_z    <= '0;
    in_if.entry_index <= '0;
    psel              <= 1'b0;
    penable           <= 1'b0;
    pwrite            <= 1'b0;
    paddr             <= '0;
    pwdata            <= '0;

    phase_spacing = '{0, 32'h7FFF_FFFF, 13107, 1, $urandom_range(1 << 20), 65536};
    phase_idle    = '{0, 82, 0, 35, 82, 0};
    phase_stall   = '{0, 0, 82, 35, 0, 82};

    // before fill, fill with extreme span, exact spacing edge, saturating distance
    directed_rows.push_back(mk_row(CMD_READ, '0, '0, '0, '0, '0, '0, 8'd0,
                                   1'b1, ST_READ_EARLY));
    directed_rows.push_back(mk_row(CMD_READ, COORD_MAX, COORD_MIN, '1, COORD_MIN, COORD_MAX,
                                   '1, 8'd255, 1'b1, ST_READ_EARLY));
    directed_rows.push_back(mk_row(CMD_UPDATE, COORD_MIN, COORD_MAX, 32'h0001_8000,
                                   COORD_MAX, COORD_MIN, 32'hFFFF_0000, 8'd0,
                                   1'b1, ST_FILLED));
    directed_rows.push_back(mk_row(CMD_READ, '0, '0, '0, '0, '0, '0, 8'd255,
                                   1'b1, ST_READ_DONE, COORD_MAX, COORD_MIN, 32'hFFFF_0000));
    directed_rows.push_back(mk_row(CMD_READ, '0, '0, '0, '0, '0, '0, 8'd0));
    directed_rows.push_back(mk_row(CMD_READ, '0, '0, '0, '0, '0, '0, 8'd127));
    directed_rows.push_back(mk_row(CMD_READ, '0, '0, '0, '0, '0, '0, 8'd254));
    directed_rows.push_back(mk_row(CMD_UPDATE, 32'hDEAD_BEEF, 32'h1234_5678, COORD_MIN,
                                   COORD_MAX, COORD_MIN, 32'd5, 8'd0, 1'b1, ST_TOO_CLOSE));
    directed_rows.push_back(mk_row(CMD_UPDATE, '0, '0, '0, COORD_MAX - RST_SPACING,
                                   COORD_MIN, '0, 8'd0, 1'b1, ST_TOO_CLOSE));
    directed_rows.push_back(mk_row(CMD_UPDATE, '0, '0, '0, COORD_MAX - RST_SPACING - 1,
                                   COORD_MIN, 32'h1234_5678, 8'hFF, 1'b1, ST_APPENDED));
    directed_rows.push_back(mk_row(CMD_READ, '0, '0, '0, '0, '0, '0, 8'd255,
                                   1'b1, ST_READ_DONE, COORD_MAX - RST_SPACING - 1,
                                   COORD_MIN, 32'h1234_5678));
    directed_rows.push_back(mk_row(CMD_READ, '0, '0, '0, '0, '0, '0, 8'd0));
    directed_rows.push_back(mk_row(CMD_UPDATE, '0, '0, '0, COORD_MIN, COORD_MAX, COORD_MAX,
                                   8'd0, 1'b1, ST_APPENDED));
    directed_rows.push_back(mk_row(CMD_UPDATE, '1, '1, '1, COORD_MIN, COORD_MAX, '0,
                                   8'd0, 1'b1, ST_TOO_CLOSE));
    directed_rows.push_back(mk_row(CMD_UPDATE, '0, '0, '0, COORD_MIN,
                                   COORD_MAX - RST_SPACING - 1, COORD_MIN, 8'd0));
    directed_rows.push_back(mk_row(CMD_READ, '0, '0, '0, '0, '0, '0, 8'd255));
    directed_rows.push_back(mk_row(CMD_READ, '0, '0, '0, '0, '0, '0, 8'd1));
    directed_rows.push_back(mk_row(CMD_READ, '1, '1, '1, '1, '1, '1, 8'd128));

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    apb_transfer(1'b0, '0);

    foreach (directed_rows[r]) begin
      send_item(directed_rows[r].stim, directed_rows[r].typed, directed_rows[r].want);
    end
    drain_results();

    for (int p = 0; p < PHASES; p++) begin
      apb_transfer(1'b1, APB_DATA_W'(phase_spacing[p]));
      spacing_reg = SPACING_W'(phase_spacing[p]);
      apb_transfer(1'b0, '0);
      sender_idle_pct    = phase_idle[p];
      receiver_stall_pct = phase_stall[p];

      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        mode           = $urandom_range(99);
        it.command     = CMD_UPDATE;
        it.follower_x  = $urandom();
        it.follower_y  = $urandom();
        it.follower_z  = $urandom();
        it.leader_x    = $urandom();
        it.leader_y    = $urandom();
        it.leader_z    = $urandom();
        it.entry_index = $urandom();
        if (mode < 30) begin
          it.command = CMD_READ;
        end else if (mode >= 45) begin
          if (mode < 60) begin
            // right at the spacing limit, or one LSB beyond it
            dx = longint'(spacing_reg);
            dy = longint'($urandom_range(1));
          end else begin
            dx = longint'($urandom_range(spacing_reg + 1));
            dy = longint'($urandom_range(spacing_reg + 1));
          end
          if ($urandom_range(1)) dx = -dx;
          if ($urandom_range(1)) dy = -dy;
          if ($urandom_range(1)) begin
            swap = dx;
            dx   = dy;
            dy   = swap;
          end
          it.leader_x = COORD_W'(longint'(last_x) + dx);
          it.leader_y = COORD_W'(longint'(last_y) + dy);
        end
        send_item(it, 1'b0, '0);
      end
      drain_results();
    end

    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
